// ===== hw/rtl/mse_pkg.sv =====
// package: shared types, opcodes and constants of the mips subset execute unit
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;

    localparam int unsigned DATA_BYTES_DEF = 65536;
    localparam int unsigned XLEN           = 32;
    localparam int unsigned NREGS          = 32;

    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SW      = 6'd43;

    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_SLT     = 6'd42;

    localparam logic [4:0] REG_LO = 5'd10;
    localparam logic [4:0] REG_HI = 5'd11;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_SLT, ALU_SLL, ALU_SRL
    } alu_op_t;

    typedef enum logic [1:0] {
        MD_MUL, MD_DIVS, MD_DIVU
    } md_mode_t;

    typedef struct packed {
        logic        start;
        md_mode_t    mode;
        logic [31:0] a;
        logic [31:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] q;
        logic [31:0] r;
    } md_rsp_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mse_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mse_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mse_alu.sv =====
// shared alu: add, subtract, logic, signed compare and shifts
`timescale 1ns / 1ps
`default_nettype none
module mse_alu
    import mse_pkg::*;
(
    input  wire alu_op_t     op,
    input  wire logic [31:0] x,
    input  wire logic [31:0] y,
    input  wire logic [4:0]  shamt,
    output logic      [31:0] res
);

    always_comb
    begin
        case (op)
            ALU_ADD: res = x + y;
            ALU_SUB: res = x - y;
            ALU_AND: res = x & y;
            ALU_OR:  res = x | y;
            ALU_XOR: res = x ^ y;
            ALU_SLT: res = {31'd0, ($signed(x) < $signed(y))};
            ALU_SLL: res = y << shamt;
            ALU_SRL: res = y >> shamt;
            default: res = x + y;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mse_muldiv.sv =====
// iterative multiply and divide unit, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module mse_muldiv
    import mse_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire md_req_t req,
    output md_rsp_t      rsp
);

    typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIX} md_state_t;

    md_state_t   state_reg;
    logic [31:0] acc_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic [31:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        mul_reg;
    logic        done_reg;
    logic [31:0] q_reg;
    logic [31:0] r_reg;

    logic        na;
    logic        nb;
    logic        sgn;
    logic [32:0] rsh;
    logic [32:0] diff;
    logic        ge;

    assign sgn  = (req.mode == MD_DIVS);
    assign na   = sgn & req.a[31];
    assign nb   = sgn & req.b[31];
    assign rsh  = {rem_reg, x_reg[31]};
    assign diff = rsh - {1'b0, y_reg};
    assign ge   = !diff[32];

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;
    assign rsp.r    = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == M_FIX);
            case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        rem_reg   <= '0;
                        mul_reg   <= (req.mode == MD_MUL);
                        neg_q_reg <= na ^ nb;
                        neg_r_reg <= na;
                        x_reg     <= na ? (32'd0 - req.a) : req.a;
                        y_reg     <= nb ? (32'd0 - req.b) : req.b;
                        state_reg <= (req.mode == MD_MUL) ? M_MUL : M_DIV;
                    end
                end
                M_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_reg <= acc_reg + x_reg;
                    end
                    x_reg   <= {x_reg[30:0], 1'b0};
                    y_reg   <= {1'b0, y_reg[31:1]};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= M_FIX;
                    end
                end
                M_DIV:
                begin
                    rem_reg <= ge ? diff[31:0] : rsh[31:0];
                    x_reg   <= {x_reg[30:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= M_FIX;
                    end
                end
                M_FIX:
                begin
                    if (mul_reg)
                    begin
                        q_reg <= acc_reg;
                        r_reg <= '0;
                    end
                    else
                    begin
                        q_reg <= neg_q_reg ? (32'd0 - x_reg) : x_reg;
                        r_reg <= neg_r_reg ? (32'd0 - rem_reg) : rem_reg;
                    end
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mips_subset_execute_unit.sv =====
// top level: sequenced execute unit for a mips32 subset
//
// channel   dir  handshake            payload
// -------   ---  -------------------  ----------------------------------------
// in        in   in_valid / in_stall  instr
// out       out  out_valid/out_stall  pc_out halted illegal reg_* rem_* mem_*
//                                     div_by_zero
//
// steps: read rs, read rt, execute; alu, logic, shift and lui then write back;
// a taken branch adds a target step; mult and div wait on the bit-serial unit;
// div by zero writes lo and hi directly; when DATA_BYTES is not a power of two
// a reciprocal multiply and one correction step wrap the address, then lb and
// lw read and capture each byte and sb and sw write each byte; all end in
// finish, halted beats straight from accept; rs and rt share one ram read port
// after reset the data ram is swept to zero, in_stall high
// a finished beat waits in the output register; the next instr is taken meanwhile
// a full, stalled output register holds the sequencer in its finish step
`timescale 1ns / 1ps
`default_nettype none
module mips_subset_execute_unit
    import mse_pkg::*;
#(
    parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] instr,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      pc_out,
    output logic             halted,
    output logic             illegal,
    output logic             reg_written,
    output logic [4:0]       reg_index,
    output logic signed [31:0] reg_value,
    output logic             rem_written,
    output logic signed [31:0] rem_value,
    output logic             mem_written,
    output logic [15:0]      mem_addr,
    output logic             div_by_zero
);

    localparam int unsigned AW       = $clog2(DATA_BYTES);
    localparam bit          IS_POW2  = ((DATA_BYTES & (DATA_BYTES - 1)) == 0);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_BYTES - 1);
    // floor(2^(32+AW) / DATA_BYTES): quotient estimate is exact or one low
    localparam logic [32:0] RECIP = 33'((64'd1 << (32 + AW)) / 64'(DATA_BYTES));
    localparam logic [AW:0] N_EXT = (AW + 1)'(DATA_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_RT, S_EXEC, S_BRANCH, S_MD_WAIT, S_ADDR_WAIT,
        S_MEM_RD, S_MEM_CAP, S_MEM_WR, S_WB, S_WB_REM, S_FINISH
    } state_t;

    state_t      state_reg;
    logic [31:0] ir_reg;
    logic [31:0] pc_reg;
    logic [31:0] npc_reg;
    logic        halt_reg;
    logic        hlt_item_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic        wr_reg;
    logic [4:0]  widx_reg;
    logic [31:0] wval_reg;
    logic        remw_reg;
    logic [31:0] rval_reg;
    logic        memw_reg;
    logic [AW-1:0] ea_reg;
    logic [AW-1:0] ptr_reg;
    logic [1:0]  cnt_reg;
    logic        dz_reg;
    logic        ill_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [NREGS-1:0] rf_vld_reg;
    logic [4:0]  rd_idx_reg;
    logic [31:0] ea_raw_reg;
    logic [31:0] qe_reg;
    logic [AW:0] rm_reg;

    logic          out_valid_reg;
    logic [31:0]   pc_out_reg;
    logic          halted_reg;
    logic          illegal_reg;
    logic          reg_written_reg;
    logic [4:0]    reg_index_reg;
    logic [31:0]   reg_value_reg;
    logic          rem_written_reg;
    logic [31:0]   rem_value_reg;
    logic          mem_written_reg;
    logic [15:0]   mem_addr_reg;
    logic          div_by_zero_reg;

    // instruction fields
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [5:0]  fn;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] zimm;

    assign op   = ir_reg[31:26];
    assign rs   = ir_reg[25:21];
    assign rt   = ir_reg[20:16];
    assign rd   = ir_reg[15:11];
    assign sh   = ir_reg[10:6];
    assign fn   = ir_reg[5:0];
    assign imm  = ir_reg[15:0];
    assign simm = sext16(imm);
    assign zimm = {16'd0, imm};

    // register file ram, valid bits stand in for the reset clear
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [4:0]  rf_raddr;
    logic [31:0] rf_rdata;
    logic [31:0] rf_rd;

    mse_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    assign rf_rd = rf_vld_reg[rd_idx_reg] ? rf_rdata : 32'd0;

    // byte data ram
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [7:0]    dm_wdata;
    logic [7:0]    dm_rdata;

    mse_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dm (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (ptr_reg),
        .rdata (dm_rdata)
    );

    // shared alu
    alu_op_t     alu_op;
    logic [31:0] alu_x;
    logic [31:0] alu_y;
    logic [4:0]  alu_sh;
    logic [31:0] alu_res;

    mse_alu u_alu (
        .op    (alu_op),
        .x     (alu_x),
        .y     (alu_y),
        .shamt (alu_sh),
        .res   (alu_res)
    );

    // shared multiply / divide unit
    md_req_t md_req;
    md_rsp_t md_rsp;

    mse_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    logic is_load;
    logic last_byte;
    logic br_taken;
    logic [AW-1:0] ptr_inc;

    assign is_load   = (op == OP_LB) || (op == OP_LW);
    assign last_byte = (op == OP_LB) || (op == OP_SB) || (cnt_reg == 2'd3);
    assign ptr_inc   = (ptr_reg == LAST_ADDR) ? '0 : ptr_reg + AW'(1);

    // address wrap for a depth that is not a power of two
    logic [65:0]   recip_prod;
    logic [31:0]   qe_next;
    logic [31:0]   rm_full;
    logic [AW-1:0] ea_wrapped;

    assign recip_prod = 66'(ea_raw_reg) * 66'(RECIP);
    assign qe_next    = 32'(recip_prod >> (32 + AW));
    assign rm_full    = ea_raw_reg - qe_reg * 32'(DATA_BYTES);
    assign ea_wrapped = (rm_reg >= N_EXT) ? AW'(rm_reg - N_EXT) : rm_reg[AW-1:0];

    always_comb
    begin
        br_taken = 1'b0;
        case (op)
            OP_BEQ:    br_taken = (alu_res == 32'd0);
            OP_BNE:    br_taken = (alu_res != 32'd0);
            OP_REGIMM: br_taken = !a_reg[31];
            OP_BGTZ:   br_taken = !a_reg[31] && (a_reg != 32'd0);
            default:   br_taken = 1'b0;
        endcase
    end

    // alu operand selection
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_x  = a_reg;
        alu_y  = simm;
        alu_sh = sh;
        if (state_reg == S_BRANCH)
        begin
            alu_x = pc_reg;
            alu_y = {simm[29:0], 2'b00};
        end
        else
        begin
            case (op)
                OP_SPECIAL:
                begin
                    alu_y = rf_rd;
                    case (fn)
                        FN_ADD:  alu_op = ALU_ADD;
                        FN_SUB:  alu_op = ALU_SUB;
                        FN_AND:  alu_op = ALU_AND;
                        FN_OR:   alu_op = ALU_OR;
                        FN_XOR:  alu_op = ALU_XOR;
                        FN_SLT:  alu_op = ALU_SLT;
                        FN_SLL:  alu_op = ALU_SLL;
                        FN_SRL:  alu_op = ALU_SRL;
                        default: alu_op = ALU_ADD;
                    endcase
                end
                OP_SLTI: alu_op = ALU_SLT;
                OP_ANDI:
                begin
                    alu_op = ALU_AND;
                    alu_y  = zimm;
                end
                OP_ORI:
                begin
                    alu_op = ALU_OR;
                    alu_y  = zimm;
                end
                OP_LUI:
                begin
                    alu_op = ALU_SLL;
                    alu_y  = zimm;
                    alu_sh = 5'd16;
                end
                OP_BEQ, OP_BNE:
                begin
                    alu_op = ALU_SUB;
                    alu_y  = rf_rd;
                end
                default: alu_op = ALU_ADD;
            endcase
        end
    end

    // muldiv start, only from the execute step
    always_comb
    begin
        md_req.start = 1'b0;
        md_req.mode  = MD_MUL;
        md_req.a     = a_reg;
        md_req.b     = rf_rd;
        if (state_reg == S_EXEC)
        begin
            if (op == OP_SPECIAL && fn == FN_MULT)
            begin
                md_req.start = 1'b1;
            end
            else if (op == OP_SPECIAL && fn == FN_DIV && rf_rd != 32'd0)
            begin
                md_req.start = 1'b1;
                md_req.mode  = MD_DIVS;
            end
        end
    end

    // ram ports
    always_comb
    begin
        rf_raddr = 5'd0;
        rf_we    = 1'b0;
        rf_waddr = widx_reg;
        rf_wdata = wval_reg;
        dm_we    = 1'b0;
        dm_waddr = ptr_reg;
        dm_wdata = b_reg[8*cnt_reg +: 8];
        case (state_reg)
            S_IDLE:   rf_raddr = instr[25:21];
            S_RD_RT:  rf_raddr = rt;
            S_WB:     rf_we = wr_reg;
            S_WB_REM:
            begin
                rf_we    = 1'b1;
                rf_waddr = REG_HI;
                rf_wdata = rval_reg;
            end
            S_CLEAR:
            begin
                dm_we    = 1'b1;
                dm_waddr = clr_cnt_reg;
                dm_wdata = 8'd0;
            end
            S_MEM_WR: dm_we = 1'b1;
            default:  rf_raddr = 5'd0;
        endcase
    end

    logic out_take;
    logic out_load;
    assign out_take = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_FINISH) && out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            rf_vld_reg    <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg <= rf_raddr;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (rf_we)
            begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ir_reg       <= instr;
                        wr_reg       <= 1'b0;
                        widx_reg     <= '0;
                        wval_reg     <= '0;
                        remw_reg     <= 1'b0;
                        rval_reg     <= '0;
                        memw_reg     <= 1'b0;
                        dz_reg       <= 1'b0;
                        ill_reg      <= 1'b0;
                        cnt_reg      <= '0;
                        if (halt_reg || instr == 32'd0)
                        begin
                            // halted core: report the pc and nothing else
                            halt_reg     <= 1'b1;
                            hlt_item_reg <= 1'b1;
                            npc_reg      <= pc_reg;
                            state_reg    <= S_FINISH;
                        end
                        else
                        begin
                            hlt_item_reg <= 1'b0;
                            npc_reg      <= pc_reg + 32'd4;
                            state_reg    <= S_RD_RT;
                        end
                    end
                end
                S_RD_RT:
                begin
                    a_reg     <= rf_rd;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    b_reg <= rf_rd;
                    case (op)
                        OP_SPECIAL:
                        begin
                            case (fn)
                                FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_SLT,
                                FN_SLL, FN_SRL:
                                begin
                                    wr_reg    <= (rd != 5'd0);
                                    widx_reg  <= rd;
                                    wval_reg  <= alu_res;
                                    state_reg <= S_WB;
                                end
                                FN_MULT: state_reg <= S_MD_WAIT;
                                FN_DIV:
                                begin
                                    if (rf_rd == 32'd0)
                                    begin
                                        dz_reg    <= 1'b1;
                                        wr_reg    <= 1'b1;
                                        widx_reg  <= REG_LO;
                                        wval_reg  <= '1;
                                        remw_reg  <= 1'b1;
                                        rval_reg  <= a_reg;
                                        state_reg <= S_WB;
                                    end
                                    else
                                    begin
                                        state_reg <= S_MD_WAIT;
                                    end
                                end
                                FN_SYSCALL: state_reg <= S_FINISH;
                                default:
                                begin
                                    ill_reg   <= 1'b1;
                                    npc_reg   <= pc_reg;
                                    state_reg <= S_FINISH;
                                end
                            endcase
                        end
                        OP_ADDI, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI:
                        begin
                            wr_reg    <= (rt != 5'd0);
                            widx_reg  <= rt;
                            wval_reg  <= alu_res;
                            state_reg <= S_WB;
                        end
                        OP_J:
                        begin
                            npc_reg   <= {pc_reg[31:28], ir_reg[25:0], 2'b00};
                            state_reg <= S_FINISH;
                        end
                        OP_BEQ, OP_BNE, OP_REGIMM, OP_BGTZ:
                        begin
                            state_reg <= br_taken ? S_BRANCH : S_FINISH;
                        end
                        OP_LB, OP_LW, OP_SB, OP_SW:
                        begin
                            if (IS_POW2)
                            begin
                                ea_reg    <= alu_res[AW-1:0];
                                ptr_reg   <= alu_res[AW-1:0];
                                state_reg <= is_load ? S_MEM_RD : S_MEM_WR;
                            end
                            else
                            begin
                                ea_raw_reg <= alu_res;
                                state_reg  <= S_ADDR_WAIT;
                            end
                        end
                        default:
                        begin
                            ill_reg   <= 1'b1;
                            npc_reg   <= pc_reg;
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_BRANCH:
                begin
                    npc_reg   <= alu_res;
                    state_reg <= S_FINISH;
                end
                S_MD_WAIT:
                begin
                    if (md_rsp.done)
                    begin
                        wr_reg   <= 1'b1;
                        widx_reg <= REG_LO;
                        wval_reg <= md_rsp.q;
                        if (fn == FN_DIV)
                        begin
                            remw_reg <= 1'b1;
                            rval_reg <= md_rsp.r;
                        end
                        state_reg <= S_WB;
                    end
                end
                S_ADDR_WAIT:
                begin
                    // quotient estimate, remainder below twice the depth, correction
                    case (cnt_reg)
                        2'd0:
                        begin
                            qe_reg  <= qe_next;
                            cnt_reg <= 2'd1;
                        end
                        2'd1:
                        begin
                            rm_reg  <= rm_full[AW:0];
                            cnt_reg <= 2'd2;
                        end
                        default:
                        begin
                            ea_reg    <= ea_wrapped;
                            ptr_reg   <= ea_wrapped;
                            cnt_reg   <= '0;
                            state_reg <= is_load ? S_MEM_RD : S_MEM_WR;
                        end
                    endcase
                end
                S_MEM_RD: state_reg <= S_MEM_CAP;
                S_MEM_CAP:
                begin
                    if (op == OP_LB)
                    begin
                        wval_reg <= {{24{dm_rdata[7]}}, dm_rdata};
                    end
                    else
                    begin
                        wval_reg[8*cnt_reg +: 8] <= dm_rdata;
                    end
                    if (last_byte)
                    begin
                        wr_reg    <= (rt != 5'd0);
                        widx_reg  <= rt;
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 2'd1;
                        ptr_reg   <= ptr_inc;
                        state_reg <= S_MEM_RD;
                    end
                end
                S_MEM_WR:
                begin
                    memw_reg <= 1'b1;
                    if (last_byte)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 2'd1;
                        ptr_reg <= ptr_inc;
                    end
                end
                S_WB:     state_reg <= remw_reg ? S_WB_REM : S_FINISH;
                S_WB_REM: state_reg <= S_FINISH;
                S_FINISH:
                begin
                    if (out_take)
                    begin
                        pc_out_reg      <= npc_reg;
                        pc_reg          <= npc_reg;
                        halted_reg      <= hlt_item_reg;
                        illegal_reg     <= ill_reg;
                        reg_written_reg <= wr_reg;
                        reg_index_reg   <= wr_reg ? widx_reg : 5'd0;
                        reg_value_reg   <= wr_reg ? wval_reg : 32'd0;
                        rem_written_reg <= remw_reg;
                        rem_value_reg   <= remw_reg ? rval_reg : 32'd0;
                        mem_written_reg <= memw_reg;
                        mem_addr_reg    <= memw_reg ? 16'(32'(ea_reg)) : 16'd0;
                        div_by_zero_reg <= dz_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign pc_out      = pc_out_reg;
    assign halted      = halted_reg;
    assign illegal     = illegal_reg;
    assign reg_written = reg_written_reg;
    assign reg_index   = reg_index_reg;
    assign reg_value   = $signed(reg_value_reg);
    assign rem_written = rem_written_reg;
    assign rem_value   = $signed(rem_value_reg);
    assign mem_written = mem_written_reg;
    assign mem_addr    = mem_addr_reg;
    assign div_by_zero = div_by_zero_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mse_chk.sv =====
// port checker for the execute unit and its bind
`timescale 1ns / 1ps
`default_nettype none
module mse_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        halted,
    input wire logic        illegal,
    input wire logic        reg_written,
    input wire logic [4:0]  reg_index,
    input wire logic signed [31:0] reg_value,
    input wire logic        rem_written,
    input wire logic        mem_written,
    input wire logic [15:0] mem_addr
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // one instruction at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new instr taken while busy");

    // a halted beat carries no side effect
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> !reg_written && !mem_written && !illegal && !rem_written)
        else $error("halted beat with side effect");

    // unused register write fields read zero; remainder only with a register write
    a_reg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reg_written |-> reg_index == 5'd0 && reg_value == 32'sd0
        && !rem_written)
        else $error("register fields without a write");

    a_mem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mem_written |-> mem_addr == 16'd0)
        else $error("store address without a store");

endmodule

bind mips_subset_execute_unit mse_chk u_mse_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .halted      (halted),
    .illegal     (illegal),
    .reg_written (reg_written),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .rem_written (rem_written),
    .mem_written (mem_written),
    .mem_addr    (mem_addr)
);
`default_nettype wire

// ===== verif/mse_checker.sv =====
// checker: predicts and compares result beats of the mips subset execute unit
`timescale 1ns / 1ps
`default_nettype none
module mse_checker
    import mse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [31:0] instr,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] pc_out,
    input  wire logic        halted,
    input  wire logic        illegal,
    input  wire logic        reg_written,
    input  wire logic [4:0]  reg_index,
    input  wire logic [31:0] reg_value,
    input  wire logic        rem_written,
    input  wire logic [31:0] rem_value,
    input  wire logic        mem_written,
    input  wire logic [15:0] mem_addr,
    input  wire logic        div_by_zero,
    output int               fail_count,
    output int               pending,
    output int               result_count
);

    typedef struct packed {
        logic [31:0] pc;
        logic        hlt;
        logic        ill;
        logic        rw;
        logic [4:0]  ridx;
        logic [31:0] rval;
        logic        qw;
        logic [31:0] qval;
        logic        mw;
        logic [15:0] maddr;
        logic        dz;
    } retire_t;

    logic [31:0] arch_regs [32];
    logic [31:0] arch_pc;
    logic [7:0]  dmem [DATA_BYTES_DEF];
    logic        arch_halt;
    retire_t     retire_q[$];

    function automatic logic [15:0] wrap16(input logic [31:0] a);
        return a[15:0];
    endfunction

    function automatic retire_t execute_instr(input logic [31:0] ir);
        retire_t     o;
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] a, b, simm, zimm, npc, ma, mb, mq, mr;
        logic [15:0] ea;
        o = '0;
        op = ir[31:26]; rs = ir[25:21]; rt = ir[20:16]; rd = ir[15:11];
        sh = ir[10:6];  fn = ir[5:0];
        zimm = {16'h0, ir[15:0]};
        simm = {{16{ir[15]}}, ir[15:0]};
        a = arch_regs[rs]; b = arch_regs[rt];
        npc = arch_pc + 32'd4;
        ea = wrap16(a + simm);
        if (arch_halt || ir == '0) begin
            arch_halt = 1'b1;
            o.pc = arch_pc; o.hlt = 1'b1;
            return o;
        end
        if (op == OP_SPECIAL) begin
            o.rw = 1'b1; o.ridx = rd;
            case (fn)
                FN_ADD: o.rval = a + b;
                FN_SUB: o.rval = a - b;
                FN_AND: o.rval = a & b;
                FN_OR:  o.rval = a | b;
                FN_XOR: o.rval = a ^ b;
                FN_SLT: o.rval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                FN_SLL: o.rval = b << sh;
                FN_SRL: o.rval = b >> sh;
                FN_MULT: begin o.ridx = REG_LO; o.rval = a * b; end
                FN_DIV: begin
                    o.ridx = REG_LO; o.qw = 1'b1;
                    if (b == '0) begin
                        o.dz = 1'b1; o.rval = '1; o.qval = a;
                    end else begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        mq = ma / mb; mr = ma % mb;
                        o.rval = (a[31] != b[31]) ? -mq : mq;
                        o.qval = a[31] ? -mr : mr;
                    end
                end
                FN_SYSCALL: o.rw = 1'b0;
                default: begin o.rw = 1'b0; o.ill = 1'b1; end
            endcase
        end else begin
            case (op)
                OP_ADDI: begin o.rw = 1'b1; o.ridx = rt; o.rval = a + simm; end
                OP_ANDI: begin o.rw = 1'b1; o.ridx = rt; o.rval = a & zimm; end
                OP_ORI:  begin o.rw = 1'b1; o.ridx = rt; o.rval = a | zimm; end
                OP_SLTI: begin
                    o.rw = 1'b1; o.ridx = rt;
                    o.rval = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
                end
                OP_LUI:  begin o.rw = 1'b1; o.ridx = rt; o.rval = {ir[15:0], 16'h0}; end
                OP_J:    npc = {arch_pc[31:28], ir[25:0], 2'b00};
                OP_BEQ:  if (a == b) npc = arch_pc + (simm << 2);
                OP_BNE:  if (a != b) npc = arch_pc + (simm << 2);
                OP_REGIMM: if (!a[31]) npc = arch_pc + (simm << 2);
                OP_BGTZ: if (!a[31] && a != '0) npc = arch_pc + (simm << 2);
                OP_LB: begin
                    o.rw = 1'b1; o.ridx = rt;
                    o.rval = {{24{dmem[ea][7]}}, dmem[ea]};
                end
                OP_LW: begin
                    o.rw = 1'b1; o.ridx = rt;
                    o.rval = {dmem[16'(ea + 3)], dmem[16'(ea + 2)],
                              dmem[16'(ea + 1)], dmem[ea]};
                end
                OP_SB: begin o.mw = 1'b1; o.maddr = ea; dmem[ea] = b[7:0]; end
                OP_SW: begin
                    o.mw = 1'b1; o.maddr = ea;
                    for (int i = 0; i < 4; i++) dmem[16'(ea + i)] = b[8*i +: 8];
                end
                default: o.ill = 1'b1;
            endcase
        end
        if (o.ill) npc = arch_pc;
        if (o.rw && o.ridx == '0) o.rw = 1'b0;
        if (o.rw) arch_regs[o.ridx] = o.rval;
        else begin o.ridx = '0; o.rval = '0; end
        if (o.qw) arch_regs[REG_HI] = o.qval;
        arch_pc = npc;
        o.pc = npc;
        return o;
    endfunction

    task automatic check_field(input string nm, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h, got %h", nm, exp_v, act_v);
            fail_count++;
        end
    endtask

    assign pending = retire_q.size();

    always @(posedge clk) begin
        retire_t e;
        if (!rst_n) begin
            fail_count = 0; result_count = 0;
            foreach (arch_regs[i]) arch_regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            arch_pc = '0; arch_halt = 1'b0;
        end else begin
            // result side first so a same-edge input beat cannot be matched early
            if (out_valid && !out_stall) begin
                result_count++;
                if (retire_q.size() == 0) begin
                    $error("result beat with no expectation pending, pc_out %h", pc_out);
                    fail_count++;
                end else begin
                    e = retire_q.pop_front();
                    check_field("pc_out", e.pc, pc_out);
                    check_field("halted", 32'(e.hlt), 32'(halted));
                    check_field("illegal", 32'(e.ill), 32'(illegal));
                    check_field("reg_written", 32'(e.rw), 32'(reg_written));
                    check_field("reg_index", 32'(e.ridx), 32'(reg_index));
                    check_field("reg_value", e.rval, reg_value);
                    check_field("rem_written", 32'(e.qw), 32'(rem_written));
                    check_field("rem_value", e.qval, rem_value);
                    check_field("mem_written", 32'(e.mw), 32'(mem_written));
                    check_field("mem_addr", 32'(e.maddr), 32'(mem_addr));
                    check_field("div_by_zero", 32'(e.dz), 32'(div_by_zero));
                end
            end
            if (in_valid && !in_stall) retire_q.push_back(execute_instr(instr));
        end
    end

endmodule
`default_nettype wire

// ===== verif/tb_mips_subset_execute_unit.sv =====
// testbench top: instruction stimulus, result stalls and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_mips_subset_execute_unit
    import mse_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instr;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] pc_out;
    logic        halted;
    logic        illegal;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic signed [31:0] reg_value;
    logic        rem_written;
    logic signed [31:0] rem_value;
    logic        mem_written;
    logic [15:0] mem_addr;
    logic        div_by_zero;
    int          fail_count;
    int          pending;
    int          result_count;
    int          sent_count;
    logic        stimulus_done;
    logic        hold_off;      // long receiver hold-off request

    mips_subset_execute_unit u_top (.*);

    mse_checker u_chk (.*);

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // encoding helpers
    // ---------------------------------------------------------------------
    function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                          input logic [4:0] rd, input logic [4:0] sh,
                                          input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // small register pool keeps data flowing between instructions
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 12));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed ops with random operands, some noise words
    function automatic logic [31:0] random_instr();
        logic [5:0] fns [11];
        logic [5:0] ops [14];
        fns = '{FN_ADD, FN_SUB, FN_MULT, FN_DIV, FN_AND, FN_OR, FN_SLT, FN_XOR,
                FN_SLL, FN_SRL, FN_SYSCALL};
        ops = '{OP_ADDI, OP_ANDI, OP_ORI, OP_SLTI, OP_J, OP_BEQ, OP_BNE, OP_REGIMM,
                OP_BGTZ, OP_LUI, OP_LB, OP_SB, OP_LW, OP_SW};
        case ($urandom_range(0, 19))
            0: return $urandom;     // raw noise, often illegal
            1, 2, 3, 4, 5, 6, 7:
                return rtype(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                             fns[$urandom_range(0, 10)]);
            default: begin
                logic [5:0] op;
                op = ops[$urandom_range(0, 13)];
                if (op == OP_J) return {op, 26'($urandom)};
                return itype(op, pick_reg(), pick_reg(), pick_imm());
            end
        endcase
    endfunction

    task automatic send_instr(input logic [31:0] w);
        int gap;
        // random gap before the beat: mostly short, rarely long
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
            : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        instr    = w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin
        logic [31:0] dir [$];
        in_valid      = 1'b0;
        instr         = '0;
        rst_n         = 1'b0;
        sent_count    = 0;
        stimulus_done = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every operation, r0 writes, divide corner cases
        dir = '{
            itype(OP_LUI, 5'd0, 5'd1, 16'h8000),            // r1 = 0x80000000
            itype(OP_ADDI, 5'd0, 5'd2, 16'hffff),           // r2 = -1
            rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV),          // overflow divide
            rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV),          // divide by zero
            rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_MULT),
            rtype(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD),
            rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_SUB),          // write to r0 dropped
            rtype(5'd2, 5'd1, 5'd4, 5'd31, FN_SLL),
            rtype(5'd2, 5'd2, 5'd5, 5'd31, FN_SRL),
            rtype(5'd1, 5'd2, 5'd6, 5'd0, FN_SLT),
            rtype(5'd1, 5'd2, 5'd7, 5'd0, FN_AND),
            rtype(5'd1, 5'd3, 5'd8, 5'd0, FN_OR),
            rtype(5'd1, 5'd2, 5'd9, 5'd0, FN_XOR),
            rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL),
            rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'd63),           // unknown funct
            itype(6'd63, 5'd31, 5'd31, 16'hffff),           // unknown opcode
            itype(OP_SW, 5'd0, 5'd2, 16'hfffe),             // wraps past the top
            itype(OP_LW, 5'd0, 5'd12, 16'hfffe),
            itype(OP_SB, 5'd2, 5'd1, 16'h0001),
            itype(OP_LB, 5'd0, 5'd13, 16'hffff),
            itype(OP_ANDI, 5'd2, 5'd14, 16'hffff),
            itype(OP_ORI, 5'd0, 5'd15, 16'h8000),
            itype(OP_SLTI, 5'd2, 5'd16, 16'h7fff),
            itype(OP_BEQ, 5'd0, 5'd0, 16'h8000),
            itype(OP_BNE, 5'd1, 5'd2, 16'h7fff),
            itype(OP_REGIMM, 5'd2, 5'd31, 16'h0004),        // bgez not taken
            itype(OP_BGTZ, 5'd15, 5'd0, 16'hfff0),
            {OP_J, 26'h3ffffff}
        };
        foreach (dir[i]) send_instr(dir[i]);

        // random body; a zero word ends it, then a few ignored beats
        repeat (1120) send_instr(random_instr());
        send_instr('0);
        repeat (5) send_instr(random_instr());
        stimulus_done = 1'b1;
    end

    // ---------------------------------------------------------------------
    // result side: random stalls plus one long hold-off mid run
    // ---------------------------------------------------------------------
    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off)
                out_stall = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                out_stall = 1'b1;          // start of a stall
            else if (out_stall && $urandom_range(0, 3) != 0 && $urandom_range(0, 7) == 0)
                out_stall = 1'b1;
            else
                out_stall = ($urandom_range(0, 5) == 0);
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (sent_count >= 300);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(negedge clk);   // sender keeps offering, block backs up
        hold_off = 1'b0;
    end

    // ---------------------------------------------------------------------
    // end of run and verdict
    // ---------------------------------------------------------------------
    initial begin
        wait (stimulus_done);
        wait (pending == 0);
        repeat (200) @(posedge clk);
        $display("run covered %0d instruction beats and %0d checked result beats",
                 sent_count, result_count);
        if (fail_count == 0)
            $display("tb_mips_subset_execute_unit passed");
        else
            $display("tb_mips_subset_execute_unit failed");
        $finish;
    end

    // post-reset ram sweep plus ~1150 slow beats with stalls
    initial begin
        #20_000_000;
        $display("tb_mips_subset_execute_unit failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/mse_pkg.sv
hw/rtl/mse_ram.sv
hw/rtl/mse_alu.sv
hw/rtl/mse_muldiv.sv
hw/rtl/mips_subset_execute_unit.sv
hw/rtl/mse_chk.sv
verif/mse_checker.sv
verif/tb_mips_subset_execute_unit.sv
